// ----- rtl/core/psd_pkg.sv -----
package psd_pkg;

  // Default exp2 table resolution (entries per octave)
  localparam int EXP_TABLE_ENTRIES = 64;

  // ln(2) with 32 fraction bits, seed of the exp2 table
  localparam logic [63:0] LN2_Q32 = 64'd2977044472;

  // Fifth in counts: 7 semitones of 65536/12, and its half, both rounded
  localparam logic [20:0] FIFTH_FULL = 21'd38229;
  localparam logic [20:0] FIFTH_HALF = 21'd19115;

  // Exact floor(x / 3) for x below 2^25: (x * RECIP3) >> RECIP3_SHIFT
  localparam int          QUOT_W       = 25;
  localparam logic [25:0] RECIP3       = 26'd44739243;
  localparam int          RECIP3_SHIFT = 27;

  // Output saturation limits
  localparam logic signed [20:0] PITCH_MAX = 21'sh0FFFFF;
  localparam logic signed [20:0] PITCH_MIN = 21'sh100000;

  // Per-item payload carried down the pipeline
  typedef struct packed {
    logic signed [20:0] pitch;
    logic signed [21:0] full;
    logic signed [21:0] half;
    logic [18:0]        dmag;
    logic               dneg;
    logic [5:0]         shamt;
  } voice_t;

  // e^(y / 2^32) rounded to 16 fraction bits, Taylor series through the 20th power
  function automatic logic [17:0] exp2_entry(input logic [63:0] y);
    logic [63:0] sum;
    logic [63:0] term;
    sum  = 64'h1_0000_0000;
    term = 64'h1_0000_0000;
    for (int k = 1; k <= 20; k++) begin
      term = ((term * y) >> 32) / 64'(k);
      sum  = sum + term;
    end
    return 18'((sum + 64'd32768) >> 16);
  endfunction

endpackage

// ----- rtl/core/psd_front.sv -----
module psd_front #(
  parameter int ENTRIES = psd_pkg::EXP_TABLE_ENTRIES,
  localparam int AW = $clog2(ENTRIES + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [20:0]  in_pitch,
  input  logic signed [18:0]  in_spread,
  input  logic signed [18:0]  in_detune,
  input  logic                in_fifths,
  output logic                out_valid,
  input  logic                out_ready,
  output psd_pkg::voice_t     out_voice,
  output logic [AW-1:0]       out_idx,
  output logic [15:0]         out_rem
);
  import psd_pkg::*;

  localparam logic [AW-1:0] ENTRIES_C = AW'(ENTRIES);

  logic                 v_r;
  voice_t               voice_r, voice_nxt;
  logic [AW-1:0]        idx_r;
  logic [15:0]          rem_r;
  logic [18:0]          smag;
  logic [21:0]          scaled;
  logic [21:0]          lsum;
  logic [5:0]           lmag;
  logic [20:0]          fmag;
  logic [20:0]          hmag;
  logic signed [21:0]   npitch;
  logic [16+AW-1:0]     pos;

  assign in_ready = !v_r || out_ready;

  // Round spread to steps, map steps to offsets, split -pitch into octave and fraction
  always_comb begin
    smag   = in_spread[18] ? 19'(-in_spread) : 19'(in_spread);
    scaled = in_fifths ? {smag, 3'b000} : {1'b0, smag, 2'b00};
    lsum   = scaled + 22'd32768;
    lmag   = lsum[21:16];
    if (in_fifths) begin
      fmag = {lmag[5:1], 16'h0000} + (lmag[0] ? FIFTH_FULL : 21'd0);
      hmag = {1'b0, lmag[5:1], 15'h0000} + (lmag[0] ? FIFTH_HALF : 21'd0);
    end else begin
      fmag = {lmag[4:0], 16'h0000};
      hmag = {1'b0, lmag[4:0], 15'h0000};
    end
    voice_nxt.pitch = in_pitch;
    voice_nxt.full  = in_spread[18] ? -$signed({1'b0, fmag}) : $signed({1'b0, fmag});
    voice_nxt.half  = in_spread[18] ? -$signed({1'b0, hmag}) : $signed({1'b0, hmag});
    voice_nxt.dmag  = in_detune[18] ? 19'(-in_detune) : 19'(in_detune);
    voice_nxt.dneg  = in_detune[18];
    npitch          = -$signed({in_pitch[20], in_pitch});
    voice_nxt.shamt = npitch[21:16] + 6'd16;
    pos             = npitch[15:0] * ENTRIES_C;
  end

  // Stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (in_ready) begin
      voice_r <= voice_nxt;
      idx_r   <= pos[16 +: AW];
      rem_r   <= pos[15:0];
    end
  end

  assign out_valid = v_r;
  assign out_voice = voice_r;
  assign out_idx   = idx_r;
  assign out_rem   = rem_r;

endmodule

// ----- rtl/core/psd_exp.sv -----
module psd_exp #(
  parameter int ENTRIES = psd_pkg::EXP_TABLE_ENTRIES,
  localparam int AW = $clog2(ENTRIES + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  psd_pkg::voice_t  in_voice,
  input  logic [AW-1:0]    in_idx,
  input  logic [15:0]      in_rem,
  output logic             out_valid,
  input  logic             out_ready,
  output psd_pkg::voice_t  out_voice,
  output logic [17:0]      out_mant
);
  import psd_pkg::*;

  logic [17:0]   exp_tab [0:ENTRIES];
  logic [AW-1:0] idx_up;
  logic          v2_r, v3_r;
  logic          rdy2, rdy3;
  voice_t        voice2_r, voice3_r;
  logic [17:0]   lo_r, hi_r;
  logic [15:0]   rem2_r;
  logic [17:0]   diff;
  logic [33:0]   interp;
  logic [17:0]   mant_nxt;
  logic [17:0]   mant_r;

  // Constant exp2 table over one octave, ends pinned to 1.0 and 2.0
  for (genvar j = 0; j <= ENTRIES; j++) begin : g_tab
    localparam logic [63:0] Y =
      (64'(j) * LN2_Q32 + 64'(ENTRIES / 2)) / 64'(ENTRIES);
    if (j == 0) begin : g_lo
      assign exp_tab[j] = 18'd65536;
    end else if (j == ENTRIES) begin : g_hi
      assign exp_tab[j] = 18'd131072;
    end else begin : g_mid
      assign exp_tab[j] = exp2_entry(Y);
    end
  end

  assign idx_up   = AW'(in_idx + AW'(1));
  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign in_ready = rdy2;

  // Linear interpolation between neighboring entries
  always_comb begin
    diff     = hi_r - lo_r;
    interp   = diff * rem2_r + 34'd32768;
    mant_nxt = lo_r + interp[33:16];
  end

  // Advance valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy2) v2_r <= in_valid;
      if (rdy3) v3_r <= v2_r;
    end
  end

  // Table read, then mantissa
  always_ff @(posedge clk) begin
    if (rdy2) begin
      voice2_r <= in_voice;
      lo_r     <= exp_tab[in_idx];
      hi_r     <= exp_tab[idx_up];
      rem2_r   <= in_rem;
    end
    if (rdy3) begin
      voice3_r <= voice2_r;
      mant_r   <= mant_nxt;
    end
  end

  assign out_valid = v3_r;
  assign out_voice = voice3_r;
  assign out_mant  = mant_r;

endmodule

// ----- rtl/core/psd_detune.sv -----
module psd_detune (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  psd_pkg::voice_t  in_voice,
  input  logic [17:0]      in_mant,
  output logic             out_valid,
  input  logic             out_ready,
  output psd_pkg::voice_t  out_voice,
  output logic [23:0]      out_det
);
  import psd_pkg::*;

  logic                v4_r, v5_r, v6_r;
  logic                rdy4, rdy5, rdy6;
  voice_t              voice4_r, voice5_r, voice6_r;
  logic [36:0]         prod_r;
  logic [68:0]         shifted;
  logic [36:0]         hi_r;
  logic                rb_r;
  logic [37:0]         q1;
  logic [QUOT_W-1:0]   qc;
  logic [50:0]         quot;
  logic [23:0]         det_r;

  assign rdy6     = !v6_r || out_ready;
  assign rdy5     = !v5_r || rdy6;
  assign rdy4     = !v4_r || rdy5;
  assign in_ready = rdy4;

  // Scale by 2^(octaves + 16); bit 31 carries the rounding half
  assign shifted = {32'd0, prod_r} << voice4_r.shamt;

  // Round, clamp far beyond saturation, divide by three
  always_comb begin
    q1   = {1'b0, hi_r} + 38'd1 + {37'd0, rb_r};
    qc   = (q1[37:QUOT_W] != '0) ? '1 : q1[QUOT_W-1:0];
    quot = qc * RECIP3;
  end

  // Advance valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (rdy4) v4_r <= in_valid;
      if (rdy5) v5_r <= v4_r;
      if (rdy6) v6_r <= v5_r;
    end
  end

  // Multiply, shift, divide
  always_ff @(posedge clk) begin
    if (rdy4) begin
      voice4_r <= in_voice;
      prod_r   <= in_voice.dmag * in_mant;
    end
    if (rdy5) begin
      voice5_r <= voice4_r;
      hi_r     <= shifted[68:32];
      rb_r     <= shifted[31];
    end
    if (rdy6) begin
      voice6_r <= voice5_r;
      det_r    <= quot[RECIP3_SHIFT +: 24];
    end
  end

  assign out_valid = v6_r;
  assign out_voice = voice6_r;
  assign out_det   = det_r;

endmodule

// ----- rtl/core/psd_mix.sv -----
module psd_mix (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  psd_pkg::voice_t    in_voice,
  input  logic [23:0]        in_det,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [20:0] out_first,
  output logic signed [20:0] out_middle,
  output logic signed [20:0] out_top
);
  import psd_pkg::*;

  logic               v_r;
  logic signed [24:0] dsig;
  logic signed [26:0] mid_sum, top_sum;
  logic signed [20:0] first_r, middle_r, top_r;

  function automatic logic signed [20:0] sat21(input logic signed [26:0] v);
    if (v > 27'(PITCH_MAX)) return PITCH_MAX;
    if (v < 27'(PITCH_MIN)) return PITCH_MIN;
    return v[20:0];
  endfunction

  assign in_ready = !v_r || out_ready;

  // Apply detune with sign, add offsets
  always_comb begin
    dsig    = in_voice.dneg ? -$signed({1'b0, in_det}) : $signed({1'b0, in_det});
    mid_sum = 27'($signed(in_voice.pitch)) + 27'($signed(in_voice.half)) + 27'(dsig);
    top_sum = 27'($signed(in_voice.pitch)) + 27'($signed(in_voice.full)) - 27'(dsig);
  end

  // Output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (in_ready) begin
      first_r  <= in_voice.pitch;
      middle_r <= sat21(mid_sum);
      top_r    <= sat21(top_sum);
    end
  end

  assign out_valid  = v_r;
  assign out_first  = first_r;
  assign out_middle = middle_r;
  assign out_top    = top_r;

endmodule

// ----- rtl/core/pitch_spread_detune_unit.sv -----
// Three-voice pitch spreader with exp2-scaled detune.
// Pipeline: one register per stage from input beat to result beat.
// Throughput: one beat per cycle; each stage holds its beat only while the
// next stage is full and stalled, so bubbles close up under backpressure.
// Reset: rst_n low clears every stage valid; no beat is in flight afterward.
module pitch_spread_detune_unit #(
  parameter int EXP_TABLE_ENTRIES = psd_pkg::EXP_TABLE_ENTRIES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // pitch_in[20:0], spread_amount[39:21], detune_amount[58:40]
  input  logic [0:0]  in_tuser,   // fifths_on[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata   // pitch_first[20:0], pitch_middle[41:21], pitch_top[62:42]
);
  import psd_pkg::*;

  localparam int AW = $clog2(EXP_TABLE_ENTRIES + 1);

  logic               f_valid, f_ready;
  voice_t             f_voice;
  logic [AW-1:0]      f_idx;
  logic [15:0]        f_rem;
  logic               e_valid, e_ready;
  voice_t             e_voice;
  logic [17:0]        e_mant;
  logic               d_valid, d_ready;
  voice_t             d_voice;
  logic [23:0]        d_det;
  logic signed [20:0] pitch_first, pitch_middle, pitch_top;

  // Stage 1: decode spread, split pitch
  psd_front #(.ENTRIES(EXP_TABLE_ENTRIES)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_pitch  ($signed(in_tdata[20:0])),
    .in_spread ($signed(in_tdata[39:21])),
    .in_detune ($signed(in_tdata[58:40])),
    .in_fifths (in_tuser[0]),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_voice (f_voice),
    .out_idx   (f_idx),
    .out_rem   (f_rem)
  );

  // Stages 2-3: exp2 table and interpolation
  psd_exp #(.ENTRIES(EXP_TABLE_ENTRIES)) u_exp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_voice  (f_voice),
    .in_idx    (f_idx),
    .in_rem    (f_rem),
    .out_valid (e_valid),
    .out_ready (e_ready),
    .out_voice (e_voice),
    .out_mant  (e_mant)
  );

  // Stages 4-6: detune magnitude
  psd_detune u_detune (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (e_valid),
    .in_ready  (e_ready),
    .in_voice  (e_voice),
    .in_mant   (e_mant),
    .out_valid (d_valid),
    .out_ready (d_ready),
    .out_voice (d_voice),
    .out_det   (d_det)
  );

  // Stage 7: sum and saturate into the output register
  psd_mix u_mix (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (d_valid),
    .in_ready   (d_ready),
    .in_voice   (d_voice),
    .in_det     (d_det),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_first  (pitch_first),
    .out_middle (pitch_middle),
    .out_top    (pitch_top)
  );

  assign out_tdata = {1'b0, pitch_top, pitch_middle, pitch_first};

endmodule

// ----- rtl/core/psd_checker.sv -----
module psd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [63:0] in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata
);

  logic [6:0] acc_r;
  logic [6:0] zero_r;
  logic       in_beat;
  logic       in_zero;

  assign in_beat = in_tvalid && in_tready;
  assign in_zero = (in_tdata[39:21] == 19'd0) && (in_tdata[58:40] == 19'd0);

  // Track beats that entered while the output side kept flowing
  always_ff @(posedge clk) begin
    if (!rst_n || !out_tready) begin
      acc_r  <= '0;
      zero_r <= '0;
    end else begin
      acc_r  <= {acc_r[5:0], in_beat};
      zero_r <= {zero_r[5:0], in_beat && in_zero};
    end
  end

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // A free output side never backs up the input side
  a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled with output ready");

  // A result is waiting at the output when nothing has stalled since the beat entered
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    acc_r[6] && out_tready |-> out_tvalid)
    else $error("result missing after pipeline latency");

  // No spread and no detune gives three equal voices
  a_unison: assert property (@(posedge clk) disable iff (!rst_n)
    zero_r[6] && out_tready |->
      (out_tdata[41:21] == out_tdata[20:0]) && (out_tdata[62:42] == out_tdata[20:0]))
    else $error("voices differ with zero spread and detune");

endmodule

bind pitch_spread_detune_unit psd_checker u_psd_checker (.*);

// ----- sim/pitch_spread_detune_unit_test.sv -----
`timescale 1ns / 1ps

module pitch_spread_detune_unit_test;

  localparam int              TABLE_N        = psd_pkg::EXP_TABLE_ENTRIES;
  localparam longint unsigned LN2_Q32        = 64'd2977044472;
  // 4 semitones at 65536 counts per octave: d * m / (3 * 65536)
  localparam longint unsigned DETUNE_DEN     = 64'd196608;
  localparam longint          VOICE_MAX      = 1048575;
  localparam longint          VOICE_MIN      = -1048576;
  localparam int              DRAIN_CYCLES   = 20;
  localparam int              WATCHDOG_LIMIT = 2000;
  localparam int              PRINT_LIMIT    = 50;

  typedef struct packed {
    logic signed [20:0] top;
    logic signed [20:0] middle;
    logic signed [20:0] first;
  } voice_trio_t;

  typedef enum int {
    READY_ALWAYS,
    READY_COIN,
    READY_PERIODIC,
    READY_LONG_HOLD
  } ready_mode_e;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;   // pitch_in[20:0], spread_amount[39:21], detune_amount[58:40]
  logic [0:0]  in_tuser;   // fifths_on[0]
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;  // pitch_first[20:0], pitch_middle[41:21], pitch_top[62:42]

  longint unsigned exp2_q16 [0:TABLE_N];
  voice_trio_t     expected_voices[$];
  int unsigned     mismatch_count;
  int unsigned     idle_cycles;
  int unsigned     burst_left;

  pitch_spread_detune_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #6 clk = ~clk;

  // Build the 2^(j/N) table with 16 fraction bits, endpoints exact
  initial begin : build_exp2_table
    longint unsigned y;
    longint unsigned sum;
    longint unsigned term;
    for (int j = 0; j <= TABLE_N; j++) begin
      y    = (longint'(j) * LN2_Q32 + TABLE_N / 2) / TABLE_N;
      sum  = 64'h1_0000_0000;
      term = 64'h1_0000_0000;
      for (longint unsigned k = 1; k <= 20; k++) begin
        term = ((term * y) >> 32) / k;
        sum  = sum + term;
      end
      exp2_q16[j] = (sum + 32768) >> 16;
    end
    exp2_q16[0]       = 65536;
    exp2_q16[TABLE_N] = 131072;
  end

  function automatic longint clamp_voice(input longint v);
    if (v > VOICE_MAX) return VOICE_MAX;
    if (v < VOICE_MIN) return VOICE_MIN;
    return v;
  endfunction

  // Work out the three voice pitches for one input beat
  function automatic voice_trio_t predict_voices(input logic signed [20:0] pitch,
                                                 input logic signed [18:0] spread,
                                                 input logic signed [18:0] detune,
                                                 input logic fifths);
    longint          pv, sv, dv, full_c, half_c, xu, oct, det;
    longint unsigned steps, smag, lmag, semis, frac, pos, idx, rem, mant;
    longint unsigned dmag, prod, num, den;
    voice_trio_t     trio;
    pv = pitch;
    sv = spread;
    dv = detune;

    // Round spread to a step count, then map it to semitones
    steps  = fifths ? 8 : 4;
    smag   = (sv < 0) ? -sv : sv;
    lmag   = (smag * steps + 32768) >> 16;
    semis  = fifths ? 12 * (lmag / 2) + 7 * (lmag % 2) : 12 * lmag;
    full_c = longint'((semis * 65536 + 6) / 12);
    half_c = longint'((semis * 65536 + 12) / 24);
    if (sv < 0) begin
      full_c = -full_c;
      half_c = -half_c;
    end

    // Split -pitch into whole octaves and fraction, interpolate the mantissa
    xu   = -pv + 17 * 65536;
    oct  = (xu >> 16) - 17;
    frac = xu & 64'hFFFF;
    pos  = frac * TABLE_N;
    idx  = pos >> 16;
    rem  = pos & 64'hFFFF;
    mant = exp2_q16[idx] + (((exp2_q16[idx + 1] - exp2_q16[idx]) * rem + 32768) >> 16);

    // Scale detune by 4 semitones and 2^octaves, round half away from zero
    dmag = (dv < 0) ? -dv : dv;
    prod = dmag * mant;
    if (oct >= 0) begin
      num = prod << oct;
      den = DETUNE_DEN;
    end else begin
      num = prod;
      den = DETUNE_DEN << (-oct);
    end
    det = longint'((num + den / 2) / den);
    if (dv < 0) det = -det;

    trio.first  = pitch;
    trio.middle = 21'(clamp_voice(pv + half_c + det));
    trio.top    = 21'(clamp_voice(pv + full_c - det));
    return trio;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT)
      $display("%0t ns: %s mismatch, got %0d, want %0d", $time, what, got, want);
  endtask

  // Drive one beat in bursts with random gaps, predict it once accepted
  task automatic send_voice(input logic signed [20:0] pitch, input logic signed [18:0] spread,
                            input logic signed [18:0] detune, input logic fifths);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, detune, spread, pitch};
    in_tuser  <= fifths;
    do @(posedge clk); while (!in_tready);
    expected_voices.push_back(predict_voices(pitch, spread, detune, fifths));
    burst_left--;
    @(negedge clk);
  endtask

  // Hold off the sender until every pending result has come back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_voices.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic test_field_extremes();
    send_voice(21'sd0, 19'sd0, 19'sd0, 1'b0);
    send_voice(21'sd655360, 19'sd65536, 19'sd65536, 1'b0);
    send_voice(-21'sd655360, -19'sd65536, -19'sd65536, 1'b1);
    send_voice(-21'sd655360, 19'sd131072, 19'sd131072, 1'b1);
    send_voice(21'sd655360, -19'sd131072, -19'sd131072, 1'b0);
    // Field limits: push the middle and top voices into saturation (the last beat saturates top only)
    send_voice(21'sd1048575, 19'sd131072, 19'sd131072, 1'b0);
    send_voice(21'sd1048575, 19'sd262143, 19'sd262143, 1'b1);
    send_voice(-21'sd1048576, -19'sd262144, -19'sd262144, 1'b1);
    send_voice(-21'sd1048576, -19'sd131072, 19'sd262143, 1'b0);
    send_voice(21'sd1048575, 19'sd0, -19'sd262144, 1'b0);
  endtask

  // Spread exactly on and just under the half-step ties, both signs
  task automatic test_step_rounding();
    send_voice(21'sd0, 19'sd8192, 19'sd0, 1'b0);
    send_voice(21'sd0, 19'sd8191, 19'sd0, 1'b0);
    send_voice(21'sd0, -19'sd8192, 19'sd0, 1'b0);
    send_voice(21'sd0, 19'sd4096, 19'sd0, 1'b1);
    send_voice(21'sd0, -19'sd4096, 19'sd0, 1'b1);
    send_voice(21'sd0, 19'sd12288, 19'sd0, 1'b1);
    send_voice(21'sd0, 19'sd20480, 19'sd0, 1'b1);
    send_voice(21'sd0, -19'sd20479, 19'sd0, 1'b1);
  endtask

  // Octave boundaries and the last table segment of the exp2 lookup
  task automatic test_exp2_segments();
    send_voice(-21'sd1, 19'sd0, 19'sd65536, 1'b0);
    send_voice(21'sd1, 19'sd0, 19'sd65536, 1'b0);
    send_voice(-21'sd65535, 19'sd0, -19'sd65536, 1'b0);
    send_voice(21'sd65536, 19'sd0, 19'sd1, 1'b1);
    send_voice(21'sd1024, 19'sd0, -19'sd3, 1'b1);
  endtask

  task automatic test_random_in_range(input int unsigned count);
    longint pv, sv, dv;
    logic   fifths;
    for (int unsigned n = 0; n < count; n++) begin
      fifths = 1'($urandom_range(0, 1));
      pv     = longint'($urandom_range(0, 1310720)) - 655360;
      // Bias a share of spread values onto the rounding ties
      if ($urandom_range(0, 3) == 0)
        sv = (longint'($urandom_range(0, 64)) - 32) * (fifths ? 4096 : 8192)
             + longint'($urandom_range(0, 2)) - 1;
      else
        sv = longint'($urandom_range(0, 262144)) - 131072;
      if ($urandom_range(0, 7) == 0)
        dv = 0;
      else
        dv = longint'($urandom_range(0, 262144)) - 131072;
      send_voice(21'(pv), 19'(sv), 19'(dv), fifths);
    end
  endtask

  task automatic test_random_full_field(input int unsigned count);
    for (int unsigned n = 0; n < count; n++)
      send_voice(21'($urandom), 19'($urandom), 19'($urandom), 1'($urandom));
  endtask

  // Receiver backpressure: switch between ready patterns at random
  ready_mode_e ready_mode;
  int unsigned ready_left;
  int unsigned ready_phase;
  always @(negedge clk) begin
    if (ready_left == 0) begin
      ready_mode = ready_mode_e'($urandom_range(0, 3));
      ready_left = $urandom_range(20, 120);
    end
    ready_left--;
    ready_phase++;
    case (ready_mode)
      READY_ALWAYS:    out_tready <= 1'b1;
      READY_COIN:      out_tready <= 1'($urandom_range(0, 1));
      READY_PERIODIC:  out_tready <= (ready_phase % 5) < 3;
      READY_LONG_HOLD: out_tready <= (ready_phase % 12) >= 9;
      default:         out_tready <= 1'b1;
    endcase
  end

  // Compare each result beat against the oldest prediction
  always @(posedge clk) begin
    voice_trio_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_voices.size() == 0) begin
        report_mismatch("unexpected beat", $signed(out_tdata[20:0]), 0);
      end else begin
        want = expected_voices.pop_front();
        if (out_tdata[20:0] !== want.first)
          report_mismatch("pitch_first", $signed(out_tdata[20:0]), want.first);
        if (out_tdata[41:21] !== want.middle)
          report_mismatch("pitch_middle", $signed(out_tdata[41:21]), want.middle);
        if (out_tdata[62:42] !== want.top)
          report_mismatch("pitch_top", $signed(out_tdata[62:42]), want.top);
      end
    end
  end

  // End the run when no beat moves on either side for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = '0;
    out_tready     = 1'b0;
    mismatch_count = 0;
    idle_cycles    = 0;
    burst_left     = 0;
    ready_left     = 0;
    ready_phase    = 0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_field_extremes();
    wait_drained();
    test_step_rounding();
    test_exp2_segments();
    wait_drained();
    test_random_in_range(900);
    wait_drained();
    test_random_full_field(380);

    // Drain, then keep watching the output for stray beats
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- pitch_spread_detune_unit.f -----
rtl/core/psd_pkg.sv
rtl/core/psd_front.sv
rtl/core/psd_exp.sv
rtl/core/psd_detune.sv
rtl/core/psd_mix.sv
rtl/core/pitch_spread_detune_unit.sv
rtl/core/psd_checker.sv
sim/pitch_spread_detune_unit_test.sv
